@@ rtl/core/line_edit_coalescer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Line edit coalescer assertion macros
// Shared property macros for the checker of the line edit coalescer.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_COALESCER_UNIT_DEFINES_SVH
`define LINE_EDIT_COALESCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/lec_pkg.sv @@
// ----------------------------------------------------------------------------
// Line edit coalescer package
// Payload types, command codes, datapath operations and saturation helpers.
// ----------------------------------------------------------------------------
package lec_pkg;

   localparam int LW    = 20;
   localparam int ACC_W = LW + 8;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic [LW-1:0] begin_line;
      logic [LW-1:0] begin_column;
      logic [LW-1:0] end_line;
      logic          at_end;
   } req_type;

   typedef struct packed {
      logic signed [LW:0] old_line;
      logic [LW-1:0]      cur_line;
      logic [LW-1:0]      lines_removed;
      logic [LW-1:0]      lines_added;
      logic               entry_valid;
      logic               last;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [LW:0] old_line;
      logic [LW-1:0]      cur_line;
      logic [LW-1:0]      removed;
      logic [LW-1:0]      added;
   } entry_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SCAN_RD,
      OP_SCAN_EAT,
      OP_FOLD_A,
      OP_FOLD_B,
      OP_DROP,
      OP_COPY_RD,
      OP_COPY_WR,
      OP_INSERT,
      OP_COMMIT,
      OP_FLUSH_RD,
      OP_FLUSH_OUT,
      OP_FLUSH_EMPTY,
      OP_FLUSH_END
   } dp_op_type;

   typedef struct packed {
      logic scan_done;
      logic drop;
      logic insert_now;
      logic copy_done;
      logic flush_empty;
      logic flush_done;
   } dp_stat_type;

   function automatic acc_type uext(input logic [LW-1:0] v);
      return $signed({{(ACC_W-LW){1'b0}}, v});
   endfunction

   function automatic acc_type sext(input logic signed [LW:0] v);
      return $signed({{(ACC_W-LW-1){v[LW]}}, v});
   endfunction

   function automatic logic [LW-1:0] sat_u(input acc_type v);
      logic [LW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > uext({LW{1'b1}})) begin
         r = {LW{1'b1}};
      end else begin
         r = v[LW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [LW:0] sat_s(input acc_type v);
      logic signed [LW:0] r;
      if (v < sext({1'b1, {LW{1'b0}}})) begin
         r = {1'b1, {LW{1'b0}}};
      end else if (v > sext({1'b0, {LW{1'b1}}})) begin
         r = {1'b0, {LW{1'b1}}};
      end else begin
         r = v[LW:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/lec_ctrl.sv @@
// ----------------------------------------------------------------------------
// Line edit coalescer controller
// Sequences the scan, fold, copy and flush phases of the datapath.
// ----------------------------------------------------------------------------
module lec_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           cmd,
   output logic                 busy,
   output lec_pkg::dp_op_type   op,
   input  lec_pkg::dp_stat_type stat
);
   import lec_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_EAT,
      S_FOLD_A,
      S_FOLD_B,
      S_COPY,
      S_COPY_WR,
      S_FLUSH,
      S_FLUSH_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      op       = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (cmd == CMD_FLUSH) begin
                  op       = OP_LOAD;
                  state_in = S_FLUSH;
               end else if (cmd != CMD_UNUSED) begin
                  op       = OP_LOAD;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_FOLD_A;
            end else begin
               op       = OP_SCAN_RD;
               state_in = S_EAT;
            end
         end
         S_EAT: begin
            op       = OP_SCAN_EAT;
            state_in = S_SCAN;
         end
         S_FOLD_A: begin
            op       = OP_FOLD_A;
            state_in = S_FOLD_B;
         end
         S_FOLD_B: begin
            if (stat.drop) begin
               op       = OP_DROP;
               state_in = S_IDLE;
            end else begin
               op       = OP_FOLD_B;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            if (stat.insert_now) begin
               op = OP_INSERT;
            end else if (stat.copy_done) begin
               op       = OP_COMMIT;
               state_in = S_IDLE;
            end else begin
               op       = OP_COPY_RD;
               state_in = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            op       = OP_COPY_WR;
            state_in = S_COPY;
         end
         S_FLUSH: begin
            if (stat.flush_empty) begin
               op       = OP_FLUSH_EMPTY;
               state_in = S_IDLE;
            end else if (stat.flush_done) begin
               op       = OP_FLUSH_END;
               state_in = S_IDLE;
            end else begin
               op       = OP_FLUSH_RD;
               state_in = S_FLUSH_OUT;
            end
         end
         S_FLUSH_OUT: begin
            op       = OP_FLUSH_OUT;
            state_in = S_FLUSH;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/core/lec_dp.sv @@
// ----------------------------------------------------------------------------
// Line edit coalescer datapath
// Ping-pong entry table, scan accumulators, fold arithmetic and result stage.
// ----------------------------------------------------------------------------
module lec_dp #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lec_pkg::req_type      req,
   input  lec_pkg::dp_op_type    op,
   output lec_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output lec_pkg::rsp_type      rsp
);
   import lec_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // Two banks: each edit reads the live bank and rebuilds the other.
   entry_type mem [2][MAX_ENTRIES];
   entry_type rd_ff;

   logic          bank_ff;
   logic [CW-1:0] cnt_ff;
   logic          ovf_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] wr_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] abs_ff;
   logic [LW-1:0] pos_ff;
   logic [LW-1:0] mag_ff;
   acc_type       end_ff;
   logic          add_mode_ff;
   logic          rem_mode_ff;
   logic          found_ff;
   logic          eating_ff;
   entry_type     prev_ff;
   acc_type       acc_rem_ff;
   acc_type       acc_add_ff;
   logic          merge_ff;
   logic signed [LW:0] mold_ff;
   logic [LW-1:0] mnl_ff;
   acc_type       radd_ff;
   acc_type       rrem_ff;
   entry_type     mt_ff;
   logic          ins_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   // Load decode.
   logic [LW-1:0] ld_pos;
   logic          ld_ins;
   logic          ld_gt;
   logic          ld_lt;

   // Scan step.
   logic    sc_past;
   acc_type sc_rf;
   acc_type sc_a;
   acc_type sc_min;

   // Fold steps.
   logic               fa_merge;
   logic signed [LW:0] fa_old;
   acc_type            fb_avail;
   acc_type            fb_take;

   // Copy step.
   logic [CW:0]   cp_k1;
   logic [CW:0]   cp_iabs;
   logic          wr_en;
   entry_type     wr_data;
   entry_type     cp_e;

   always_comb begin
      ld_pos = (req.at_end && (req.begin_line != '0)) ? req.begin_line - 1'b1
                                                      : req.begin_line;
      ld_ins = (req.cmd == CMD_INSERT);
      ld_gt  = (req.end_line > ld_pos);
      ld_lt  = (req.end_line < ld_pos);

      sc_past = found_ff || (rd_ff.cur_line > pos_ff);
      sc_rf   = end_ff - uext(rd_ff.cur_line);
      sc_a    = uext(rd_ff.added);
      sc_min  = (sc_rf < sc_a) ? sc_rf : sc_a;

      fa_merge = (i_ff != '0) &&
                 (uext(pos_ff) <= uext(prev_ff.cur_line) + uext(prev_ff.added));
      fa_old   = (i_ff != '0) ?
                 sat_s(uext(pos_ff) - (uext(prev_ff.added) - uext(prev_ff.removed))) :
                 $signed({1'b0, pos_ff});

      fb_avail = uext(mnl_ff) + radd_ff - uext(pos_ff);
      if (fb_avail <= 0) begin
         fb_take = '0;
      end else if (uext(mag_ff) < fb_avail) begin
         fb_take = uext(mag_ff);
      end else begin
         fb_take = fb_avail;
      end

      cp_k1   = {1'b0, idx_ff} + {{CW{1'b0}}, 1'b1};
      cp_iabs = {1'b0, i_ff} + {1'b0, abs_ff};

      cp_e = rd_ff;
      if (add_mode_ff) begin
         cp_e.cur_line = sat_u(uext(rd_ff.cur_line) + uext(mag_ff));
      end else if (rem_mode_ff) begin
         cp_e.cur_line = sat_u(uext(rd_ff.cur_line) - uext(mag_ff));
      end

      wr_en   = 1'b0;
      wr_data = rd_ff;
      if (op == OP_INSERT) begin
         wr_en   = 1'b1;
         wr_data = mt_ff;
      end else if (op == OP_COPY_WR) begin
         if (idx_ff < i_ff) begin
            wr_en   = 1'b1;
            wr_data = (merge_ff && (cp_k1 == {1'b0, i_ff})) ? mt_ff : rd_ff;
         end else if (!(rem_mode_ff && ({1'b0, idx_ff} < cp_iabs))) begin
            // Entries covered by a removal are absorbed and not written back.
            wr_en   = 1'b1;
            wr_data = cp_e;
         end
      end

      stat.scan_done   = (idx_ff == cnt_ff);
      stat.drop        = !merge_ff && (cnt_ff >= CW'(MAX_ENTRIES));
      stat.insert_now  = !merge_ff && !ins_ff && (idx_ff == i_ff);
      stat.copy_done   = (idx_ff == cnt_ff);
      stat.flush_empty = (cnt_ff == '0);
      stat.flush_done  = (idx_ff == cnt_ff);
   end

   always_ff @(posedge clock) begin
      if ((op == OP_SCAN_RD) || (op == OP_COPY_RD) || (op == OP_FLUSH_RD)) begin
         rd_ff <= mem[bank_ff][idx_ff[AW-1:0]];
      end
      if (wr_en) begin
         mem[~bank_ff][wr_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (op)
            OP_LOAD: begin
               pos_ff      <= ld_pos;
               add_mode_ff <= ld_ins ? ld_gt : ld_lt;
               rem_mode_ff <= ld_ins ? ld_lt : ld_gt;
               mag_ff      <= ld_gt ? req.end_line - ld_pos : ld_pos - req.end_line;
               end_ff      <= uext(ld_pos) + uext(ld_gt ? req.end_line - ld_pos
                                                       : ld_pos - req.end_line);
               idx_ff      <= '0;
               i_ff        <= '0;
               abs_ff      <= '0;
               found_ff    <= 1'b0;
               eating_ff   <= 1'b1;
               acc_rem_ff  <= '0;
               acc_add_ff  <= '0;
            end
            OP_SCAN_EAT: begin
               if (!sc_past) begin
                  prev_ff <= rd_ff;
                  i_ff    <= cp_k1[CW-1:0];
               end else begin
                  found_ff <= 1'b1;
                  if (eating_ff && (uext(rd_ff.cur_line) <= end_ff)) begin
                     abs_ff     <= abs_ff + 1'b1;
                     acc_rem_ff <= acc_rem_ff + uext(rd_ff.removed) - sc_min;
                     acc_add_ff <= acc_add_ff + ((sc_a > sc_rf) ? sc_a - sc_rf : '0);
                  end else begin
                     eating_ff <= 1'b0;
                  end
               end
               idx_ff <= cp_k1[CW-1:0];
            end
            OP_FOLD_A: begin
               merge_ff <= fa_merge;
               mold_ff  <= fa_merge ? prev_ff.old_line : fa_old;
               mnl_ff   <= fa_merge ? prev_ff.cur_line : pos_ff;
               radd_ff  <= (fa_merge ? uext(prev_ff.added) : '0) +
                           (rem_mode_ff ? acc_add_ff : '0);
               rrem_ff  <= (fa_merge ? uext(prev_ff.removed) : '0) +
                           (rem_mode_ff ? acc_rem_ff : '0);
            end
            OP_FOLD_B: begin
               mt_ff.old_line <= mold_ff;
               mt_ff.cur_line <= mnl_ff;
               if (add_mode_ff) begin
                  mt_ff.added   <= sat_u(radd_ff + uext(mag_ff));
                  mt_ff.removed <= sat_u(rrem_ff);
               end else if (rem_mode_ff) begin
                  mt_ff.added   <= sat_u(radd_ff - fb_take);
                  mt_ff.removed <= sat_u(rrem_ff + uext(mag_ff) - fb_take);
               end else begin
                  mt_ff.added   <= sat_u(radd_ff);
                  mt_ff.removed <= sat_u(rrem_ff);
               end
               idx_ff <= '0;
               wr_ff  <= '0;
               ins_ff <= 1'b0;
            end
            OP_DROP: begin
               ovf_ff <= 1'b1;
            end
            OP_COPY_WR: begin
               if (wr_en) begin
                  wr_ff <= wr_ff + 1'b1;
               end
               idx_ff <= cp_k1[CW-1:0];
            end
            OP_INSERT: begin
               wr_ff  <= wr_ff + 1'b1;
               ins_ff <= 1'b1;
            end
            OP_COMMIT: begin
               bank_ff <= ~bank_ff;
               cnt_ff  <= wr_ff;
            end
            OP_FLUSH_OUT: begin
               rsp_ff.old_line      <= rd_ff.old_line;
               rsp_ff.cur_line      <= rd_ff.cur_line;
               rsp_ff.lines_removed <= rd_ff.removed;
               rsp_ff.lines_added   <= rd_ff.added;
               rsp_ff.entry_valid   <= 1'b1;
               rsp_ff.last          <= (cp_k1 == {1'b0, cnt_ff});
               rsp_ff.overflow      <= ovf_ff;
               rsp_valid_ff         <= 1'b1;
               idx_ff               <= cp_k1[CW-1:0];
            end
            OP_FLUSH_EMPTY: begin
               rsp_ff.old_line      <= '0;
               rsp_ff.cur_line      <= '0;
               rsp_ff.lines_removed <= '0;
               rsp_ff.lines_added   <= '0;
               rsp_ff.entry_valid   <= 1'b0;
               rsp_ff.last          <= 1'b1;
               rsp_ff.overflow      <= ovf_ff;
               rsp_valid_ff         <= 1'b1;
               ovf_ff               <= 1'b0;
            end
            OP_FLUSH_END: begin
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/core/line_edit_coalescer_unit.sv @@
// ----------------------------------------------------------------------------
// Line edit coalescer
// Folds line edits into a sorted modification table and flushes it on command.
// ----------------------------------------------------------------------------
//   channel   ports                         handshake
//   request   start, busy, req_data         taken when start && !busy
//   result    rsp_valid, rsp_data           one beat per cycle rsp_valid is high
//
// An edit with n table entries makes a scan pass and a rebuild pass over the
// table, each reading one entry at a time through the one read port of the
// entry memory. A flush reads the entries in order and gives one beat per entry
// (one beat for an empty table). Reset is synchronous and needs no clearing
// pass. The result side has no stall; beats are never held.
module line_edit_coalescer_unit #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lec_pkg::req_type req_data,
   output logic             rsp_valid,
   output lec_pkg::rsp_type rsp_data
);
   import lec_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;

   lec_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_data.cmd),
      .busy  (busy),
      .op    (op),
      .stat  (stat)
   );

   lec_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .op        (op),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

@@ rtl/core/lec_checker.sv @@
// ----------------------------------------------------------------------------
// Line edit coalescer checker
// Port-level properties of the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_edit_coalescer_unit_defines.svh"

module lec_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lec_pkg::req_type req_data,
   input logic             rsp_valid,
   input lec_pkg::rsp_type rsp_data
);
   import lec_pkg::*;

   logic take_cmd;
   logic take_edit;

   assign take_cmd  = start && !busy && (req_data.cmd != CMD_UNUSED);
   assign take_edit = start && !busy &&
                      ((req_data.cmd == CMD_INSERT) || (req_data.cmd == CMD_ERASE));

   `LEC_ASSERT_NEXT(a_busy_after_cmd, clock, reset, take_cmd, busy)
   `LEC_ASSERT_NEXT(a_edit_silent, clock, reset, take_edit, !rsp_valid)
   `LEC_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid && !rsp_data.entry_valid, rsp_data.last)
   `LEC_ASSERT_NEXT(a_run_ends, clock, reset, rsp_valid && rsp_data.last, !rsp_valid)

endmodule

bind line_edit_coalescer_unit lec_checker u_lec_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
